// ----- sv/front_panel_button_debouncer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Front panel debouncer assertion macros
// Shared same-cycle and next-cycle implication property macros.
// ----------------------------------------------------------------------------
`ifndef FRONT_PANEL_BUTTON_DEBOUNCER_UNIT_ASSERT_SVH
`define FRONT_PANEL_BUTTON_DEBOUNCER_UNIT_ASSERT_SVH

// same-cycle implication
`define FPBD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FPBD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/fpbd_pkg.sv -----
// ----------------------------------------------------------------------------
// fpbd_pkg
// Types, constants and helpers shared by the front panel debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package fpbd_pkg;

   localparam int PULSE_COUNT_WIDTH_DEF = 16;
   localparam int PULSE_OUT_W           = 16;
   localparam int CSR_INDEX_W           = 8;
   localparam int CSR_DATA_W            = 16;

   typedef enum logic [1:0] {
      MODE_PIN         = 2'd0,
      MODE_TICK        = 2'd1,
      MODE_READ_PULSES = 2'd2,
      MODE_READ_CODE   = 2'd3
   } mode_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT  = 8'd3;

   localparam logic [7:0]  DEBOUNCE_RST = 8'd100;
   localparam logic [15:0] HOLD_RST     = 16'd2000;
   localparam logic [15:0] WINDOW_RST   = 16'd200;
   localparam logic [15:0] TIMEOUT_RST  = 16'd3000;

   localparam logic [3:0] CODE_NONE = 4'd0;
   localparam logic [3:0] CODE_MAX  = 4'd9;

   typedef struct packed {
      mode_type   mode;
      logic       btn_dec;
      logic       btn_inc;
      logic       capture_pin;
      logic [5:0] inputs_low;
      logic [2:0] inputs_high;
   } req_type;

   typedef struct packed {
      logic                   show_event;
      logic                   dec_event;
      logic                   inc_event;
      logic                   unlock_event;
      logic                   lock_level;
      logic [PULSE_OUT_W-1:0] pulse_count;
      logic [3:0]             input_code;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  debounce_ticks;
      logic [15:0] unlock_hold_ticks;
      logic [15:0] unlock_window;
      logic [15:0] display_timeout;
   } csr_type;

   // lowest code wins: inputs_high bit2 is code 1, inputs_low bit0 is code 9
   function automatic logic [3:0] priority_code(input logic [5:0] lo,
                                                input logic [2:0] hi);
      logic [3:0] code;
      code = CODE_NONE;
      for (int b = 0; b < 6; b++) begin
         if (lo[b]) code = 4'(9 - b);
      end
      for (int b = 0; b < 3; b++) begin
         if (hi[b]) code = 4'(3 - b);
      end
      return code;
   endfunction

endpackage

`default_nettype wire

// ----- sv/fpbd_csr.sv -----
// ----------------------------------------------------------------------------
// fpbd_csr
// Configuration register file for the front panel debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

module fpbd_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   input  wire logic [fpbd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [fpbd_pkg::CSR_DATA_W-1:0]      csr_data,
   output fpbd_pkg::csr_type                         csr
);
   import fpbd_pkg::*;

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE: csr_in.debounce_ticks    = csr_data[7:0];
            CSR_HOLD:     csr_in.unlock_hold_ticks = csr_data;
            CSR_WINDOW:   csr_in.unlock_window     = csr_data;
            CSR_TIMEOUT:  csr_in.display_timeout   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.debounce_ticks    <= DEBOUNCE_RST;
         csr_ff.unlock_hold_ticks <= HOLD_RST;
         csr_ff.unlock_window     <= WINDOW_RST;
         csr_ff.display_timeout   <= TIMEOUT_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

`default_nettype wire

// ----- sv/fpbd_core.sv -----
// ----------------------------------------------------------------------------
// fpbd_core
// Panel state and the single-pass step logic for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module fpbd_core #(
   parameter int PULSE_COUNT_WIDTH = fpbd_pkg::PULSE_COUNT_WIDTH_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step_en,
   input  fpbd_pkg::req_type   item,
   input  fpbd_pkg::csr_type   csr,
   output fpbd_pkg::rsp_type   result
);
   import fpbd_pkg::*;

   logic [7:0]                   dec_lockout_ff, dec_lockout_in;
   logic [7:0]                   inc_lockout_ff, inc_lockout_in;
   logic [7:0]                   capture_lockout_ff, capture_lockout_in;
   logic [7:0]                   inputs_lockout_ff, inputs_lockout_in;
   logic [15:0]                  display_timer_ff, display_timer_in;
   logic [15:0]                  hold_timer_ff, hold_timer_in;
   logic [PULSE_COUNT_WIDTH-1:0] pulse_total_ff, pulse_total_in;
   logic [3:0]                   latched_code_ff, latched_code_in;
   logic                         dec_pressed_ff, dec_pressed_in;
   logic                         inc_pressed_ff, inc_pressed_in;
   logic                         ignore_release_ff, ignore_release_in;
   logic                         inputs_armed_ff, inputs_armed_in;
   logic                         capture_high_ff, capture_high_in;
   rsp_type                      res;
   logic                         any_input;

   assign any_input = (item.inputs_low != '0) || (item.inputs_high != '0);

   // Written in the order the panel evaluates: each section sees the
   // updates of the ones above it.
   always_comb begin
      dec_lockout_in     = dec_lockout_ff;
      inc_lockout_in     = inc_lockout_ff;
      capture_lockout_in = capture_lockout_ff;
      inputs_lockout_in  = inputs_lockout_ff;
      display_timer_in   = display_timer_ff;
      hold_timer_in      = hold_timer_ff;
      pulse_total_in     = pulse_total_ff;
      latched_code_in    = latched_code_ff;
      dec_pressed_in     = dec_pressed_ff;
      inc_pressed_in     = inc_pressed_ff;
      ignore_release_in  = ignore_release_ff;
      inputs_armed_in    = inputs_armed_ff;
      capture_high_in    = capture_high_ff;
      res                = '0;

      case (item.mode)
         MODE_PIN: begin
            // decrement button
            if (item.btn_dec && !dec_pressed_in && dec_lockout_in == '0) begin
               dec_lockout_in = csr.debounce_ticks;
               dec_pressed_in = 1'b1;
               res.show_event = 1'b1;
            end else if (!item.btn_dec && dec_pressed_in && dec_lockout_in == '0) begin
               dec_lockout_in = csr.debounce_ticks;
               dec_pressed_in = 1'b0;
               hold_timer_in  = '0;
               if (!inc_pressed_in) begin
                  if (!ignore_release_in) res.dec_event = 1'b1;
                  ignore_release_in = 1'b0;
               end else begin
                  ignore_release_in = 1'b1;
               end
            end
            // increment button
            if (item.btn_inc && !inc_pressed_in && inc_lockout_in == '0) begin
               inc_lockout_in = csr.debounce_ticks;
               inc_pressed_in = 1'b1;
               res.show_event = 1'b1;
            end else if (!item.btn_inc && inc_pressed_in && inc_lockout_in == '0) begin
               inc_lockout_in = csr.debounce_ticks;
               inc_pressed_in = 1'b0;
               hold_timer_in  = '0;
               if (!dec_pressed_in) begin
                  if (!ignore_release_in) res.inc_event = 1'b1;
                  ignore_release_in = 1'b0;
               end else begin
                  ignore_release_in = 1'b1;
               end
            end
            // input lines: arm on all-clear, latch on first pattern after
            if (!inputs_armed_in && !any_input && inputs_lockout_in == '0) begin
               inputs_lockout_in = csr.debounce_ticks;
               inputs_armed_in   = 1'b1;
            end else if (inputs_armed_in && any_input && inputs_lockout_in == '0) begin
               inputs_lockout_in = csr.debounce_ticks;
               inputs_armed_in   = 1'b0;
               latched_code_in   = priority_code(item.inputs_low, item.inputs_high);
            end
            // capture pin, counted on the falling edge
            if (item.capture_pin && !capture_high_in && capture_lockout_in == '0) begin
               capture_lockout_in = csr.debounce_ticks;
               capture_high_in    = 1'b1;
            end else if (!item.capture_pin && capture_high_in &&
                         capture_lockout_in == '0) begin
               capture_lockout_in = csr.debounce_ticks;
               capture_high_in    = 1'b0;
               pulse_total_in     = pulse_total_in + PULSE_COUNT_WIDTH'(1);
            end
            // both buttons held
            if (item.btn_inc && item.btn_dec && dec_lockout_in == '0 &&
                inc_lockout_in == '0) begin
               if (hold_timer_in == '0) hold_timer_in = csr.unlock_hold_ticks;
               if (hold_timer_in <= csr.unlock_window) res.unlock_event = 1'b1;
            end
            if (item.btn_inc || item.btn_dec) display_timer_in = csr.display_timeout;
            if (display_timer_in == '0) res.lock_level = 1'b1;
         end
         MODE_TICK: begin
            if (dec_lockout_ff != '0)     dec_lockout_in     = dec_lockout_ff - 8'd1;
            if (inc_lockout_ff != '0)     inc_lockout_in     = inc_lockout_ff - 8'd1;
            if (capture_lockout_ff != '0) capture_lockout_in = capture_lockout_ff - 8'd1;
            if (inputs_lockout_ff != '0)  inputs_lockout_in  = inputs_lockout_ff - 8'd1;
            if (display_timer_ff != '0)   display_timer_in   = display_timer_ff - 16'd1;
            if (hold_timer_ff != '0)      hold_timer_in      = hold_timer_ff - 16'd1;
         end
         MODE_READ_PULSES: begin
            res.pulse_count = PULSE_OUT_W'(pulse_total_ff);
            pulse_total_in  = '0;
         end
         MODE_READ_CODE: begin
            res.input_code  = latched_code_ff;
            latched_code_in = CODE_NONE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_lockout_ff     <= '0;
         inc_lockout_ff     <= '0;
         capture_lockout_ff <= '0;
         inputs_lockout_ff  <= '0;
         display_timer_ff   <= '0;
         hold_timer_ff      <= '0;
         pulse_total_ff     <= '0;
         latched_code_ff    <= CODE_NONE;
         dec_pressed_ff     <= 1'b0;
         inc_pressed_ff     <= 1'b0;
         ignore_release_ff  <= 1'b0;
         inputs_armed_ff    <= 1'b0;
         capture_high_ff    <= 1'b0;
      end else if (step_en) begin
         dec_lockout_ff     <= dec_lockout_in;
         inc_lockout_ff     <= inc_lockout_in;
         capture_lockout_ff <= capture_lockout_in;
         inputs_lockout_ff  <= inputs_lockout_in;
         display_timer_ff   <= display_timer_in;
         hold_timer_ff      <= hold_timer_in;
         pulse_total_ff     <= pulse_total_in;
         latched_code_ff    <= latched_code_in;
         dec_pressed_ff     <= dec_pressed_in;
         inc_pressed_ff     <= inc_pressed_in;
         ignore_release_ff  <= ignore_release_in;
         inputs_armed_ff    <= inputs_armed_in;
         capture_high_ff    <= capture_high_in;
      end
   end

   assign result = res;

endmodule

`default_nettype wire

// ----- sv/front_panel_button_debouncer_unit.sv -----
// ----------------------------------------------------------------------------
// front_panel_button_debouncer_unit
// Qualifies front panel buttons, input lines and a capture pin into events.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per transfer - a pin sample, a millisecond tick, or a
//            read-and-clear of the pulse count or the latched input code.
//   rsp_*  : exactly one result per request, in request order.
//   csr_*  : register writes, always ready; write only while the block is idle.
// Path: a request taken lands in the input register, is evaluated by the step
//   logic and its result is held in the result register (two register stages).
// Throughput: one item per cycle while the result is not stalled; the input
//   register and the result register both advance whenever the result
//   register is empty or being taken, so the step logic runs once per cycle.
// Stall: if rsp_ready is low the result holds, one more request fills the
//   input register, then req_ready drops until the result moves.
// Reset: synchronous; both stages empty, all timers, lockouts and flags
//   cleared, registers back to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module front_panel_button_debouncer_unit #(
   parameter int PULSE_COUNT_WIDTH = fpbd_pkg::PULSE_COUNT_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  fpbd_pkg::req_type                      req_data,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output fpbd_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [fpbd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [fpbd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import fpbd_pkg::*;

   logic    req_valid_ff, req_valid_in;
   req_type req_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    out_free;
   logic    step;
   rsp_type step_result;
   csr_type csr;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid_ff && out_free;
   assign req_ready = !req_valid_ff || out_free;
   assign csr_ready = 1'b1;

   fpbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr       (csr)
   );

   fpbd_core #(
      .PULSE_COUNT_WIDTH (PULSE_COUNT_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step),
      .item    (req_data_ff),
      .csr     (csr),
      .result  (step_result)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_valid && req_ready) req_valid_in = 1'b1;
      else if (step)              req_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (step)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_data_ff <= req_data;
      if (step)                   rsp_data_ff <= step_result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- sv/fpbd_checker.sv -----
// ----------------------------------------------------------------------------
// fpbd_checker
// Port-level checks on the front panel debouncer result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "front_panel_button_debouncer_unit_assert.svh"

module fpbd_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input fpbd_pkg::rsp_type       rsp_data
);
   import fpbd_pkg::*;

   `FPBD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   `FPBD_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid right after reset")

   // both releases in one sample leave at most one release event
   `FPBD_ASSERT_IMP(a_inc_dec_excl, clock, reset, rsp_valid, !(rsp_data.inc_event && rsp_data.dec_event), "inc and dec events together")

   // read results carry no panel events
   `FPBD_ASSERT_IMP(a_read_quiet, clock, reset, rsp_valid && (rsp_data.pulse_count != '0 || rsp_data.input_code != '0), !(rsp_data.show_event || rsp_data.dec_event || rsp_data.inc_event || rsp_data.unlock_event || rsp_data.lock_level), "events on a read result")

   `FPBD_ASSERT_IMP(a_code_range, clock, reset, rsp_valid, rsp_data.input_code <= CODE_MAX, "input code out of range")

endmodule

bind front_panel_button_debouncer_unit fpbd_checker u_fpbd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- tb/front_panel_button_debouncer_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// front_panel_button_debouncer_unit_tb
// Self-checking bench for the front panel debouncer. Pin samples, ticks and
// read-and-clear requests go in through the request channel with random
// gaps. Each transfer is run through a local copy of the panel logic, and
// every response is checked field by field against the oldest prediction.
// Register settings change between phases, only while the block is empty.
// ----------------------------------------------------------------------------
module front_panel_button_debouncer_unit_tb;
   import fpbd_pkg::*;

   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int HOLDOFF_AT   = 420;
   localparam int HOLDOFF_LEN  = 150;
   localparam int REPORT_LIMIT = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   front_panel_button_debouncer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // register copy
   logic [7:0]  cfg_debounce = DEBOUNCE_RST;
   logic [15:0] cfg_hold     = HOLD_RST;
   logic [15:0] cfg_window   = WINDOW_RST;
   logic [15:0] cfg_timeout  = TIMEOUT_RST;

   // panel state copy
   logic [7:0]  dec_lock = '0, inc_lock = '0, cap_lock = '0, lines_lock = '0;
   logic [15:0] disp_timer = '0, hold_cnt = '0, pulse_cnt = '0;
   logic [3:0]  code_latch = CODE_NONE;
   logic        dec_down = 1'b0, inc_down = 1'b0, skip_release = 1'b0;
   logic        lines_armed = 1'b0, cap_level = 1'b0;

   // stimulus-side held levels
   logic       held_dec = 1'b0, held_inc = 1'b0, held_cap = 1'b0;
   logic [8:0] held_lines = '0;

   req_type panel_items[$];
   rsp_type pending_panel_results[$];

   int cycle_count    = 0;
   int items_taken    = 0;
   int results_seen   = 0;
   int mismatch_count = 0;
   int settings_used  = 0;
   int presses_seen   = 0, inc_seen = 0, dec_seen = 0, unlocks_seen = 0;
   int locks_seen     = 0, codes_read = 0, pulse_reads = 0;

   logic quiet_stretch;
   assign quiet_stretch = (cycle_count >= 1200) && (cycle_count < 1700);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_panel_results.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Advances the panel copy by one item and returns the response it gives.
   function automatic rsp_type panel_step(input req_type item);
      rsp_type    res;
      logic [8:0] lines;
      int         k;
      res   = '0;
      lines = {item.inputs_high, item.inputs_low};
      case (item.mode)
         MODE_PIN: begin
            if (item.btn_dec && !dec_down && dec_lock == 0) begin
               dec_lock = cfg_debounce;
               dec_down = 1'b1;
               res.show_event = 1'b1;
            end else if (!item.btn_dec && dec_down && dec_lock == 0) begin
               dec_lock = cfg_debounce;
               dec_down = 1'b0;
               hold_cnt = '0;
               if (inc_down) begin
                  skip_release = 1'b1;
               end else begin
                  res.dec_event = !skip_release;
                  skip_release = 1'b0;
               end
            end
            if (item.btn_inc && !inc_down && inc_lock == 0) begin
               inc_lock = cfg_debounce;
               inc_down = 1'b1;
               res.show_event = 1'b1;
            end else if (!item.btn_inc && inc_down && inc_lock == 0) begin
               inc_lock = cfg_debounce;
               inc_down = 1'b0;
               hold_cnt = '0;
               if (dec_down) begin
                  skip_release = 1'b1;
               end else begin
                  res.inc_event = !skip_release;
                  skip_release = 1'b0;
               end
            end
            if (!lines_armed && lines == 0 && lines_lock == 0) begin
               lines_lock  = cfg_debounce;
               lines_armed = 1'b1;
            end else if (lines_armed && lines != 0 && lines_lock == 0) begin
               lines_lock  = cfg_debounce;
               lines_armed = 1'b0;
               // top line is code 1, so scan down from it
               for (k = 8; k >= 0; k--) begin
                  if (lines[k]) begin
                     code_latch = 4'(9 - k);
                     break;
                  end
               end
            end
            if (item.capture_pin && !cap_level && cap_lock == 0) begin
               cap_lock  = cfg_debounce;
               cap_level = 1'b1;
            end else if (!item.capture_pin && cap_level && cap_lock == 0) begin
               cap_lock  = cfg_debounce;
               cap_level = 1'b0;
               pulse_cnt = pulse_cnt + 16'd1;
            end
            if (item.btn_dec && item.btn_inc && dec_lock == 0 && inc_lock == 0) begin
               if (hold_cnt == 0) hold_cnt = cfg_hold;
               res.unlock_event = (hold_cnt <= cfg_window);
            end
            if (item.btn_dec || item.btn_inc) disp_timer = cfg_timeout;
            res.lock_level = (disp_timer == 0);
         end
         MODE_TICK: begin
            if (dec_lock != 0)   dec_lock--;
            if (inc_lock != 0)   inc_lock--;
            if (cap_lock != 0)   cap_lock--;
            if (lines_lock != 0) lines_lock--;
            if (disp_timer != 0) disp_timer--;
            if (hold_cnt != 0)   hold_cnt--;
         end
         MODE_READ_PULSES: begin
            res.pulse_count = pulse_cnt;
            pulse_cnt = '0;
            pulse_reads++;
         end
         default: begin
            res.input_code = code_latch;
            code_latch = CODE_NONE;
            if (res.input_code != CODE_NONE) codes_read++;
         end
      endcase
      presses_seen += res.show_event;
      dec_seen     += res.dec_event;
      inc_seen     += res.inc_event;
      unlocks_seen += res.unlock_event;
      locks_seen   += res.lock_level;
      return res;
   endfunction

   // Random item: levels persist across samples, with an occasional one-sample glitch.
   function automatic req_type next_panel_item(input int unsigned tick_pct);
      req_type     item;
      int unsigned roll;
      logic [11:0] levels;
      item = 14'($urandom_range(16383));
      roll = $urandom_range(99);
      if (roll < tick_pct) begin
         item.mode = MODE_TICK;
      end else if (roll < tick_pct + 6) begin
         item.mode = MODE_READ_PULSES;
      end else if (roll < tick_pct + 12) begin
         item.mode = MODE_READ_CODE;
      end else begin
         item.mode = MODE_PIN;
         if ($urandom_range(99) < 15) held_dec = !held_dec;
         if ($urandom_range(99) < 15) held_inc = !held_inc;
         if ($urandom_range(99) < 20) held_cap = !held_cap;
         if ($urandom_range(99) < 15) begin
            if (held_lines != 0 || $urandom_range(1) == 0) held_lines = '0;
            else held_lines = 9'($urandom_range(511, 1));
         end
         levels = {held_dec, held_inc, held_cap, held_lines};
         if ($urandom_range(99) < 8) levels[$urandom_range(11)] ^= 1'b1;
         {item.btn_dec, item.btn_inc, item.capture_pin, item.inputs_high,
          item.inputs_low} = levels;
      end
      return item;
   endfunction

   function automatic req_type pin_item(input logic dec, input logic inc, input logic cap,
                                        input logic [5:0] lo, input logic [2:0] hi);
      req_type item;
      item = '{mode: MODE_PIN, btn_dec: dec, btn_inc: inc, capture_pin: cap,
               inputs_low: lo, inputs_high: hi};
      return item;
   endfunction

   function automatic req_type mode_item(input mode_type m);
      req_type item;
      item = '0;
      item.mode = m;
      return item;
   endfunction

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin : req_driver
      logic send_next;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            pending_panel_results.push_back(panel_step(req_data));
            items_taken++;
         end
         if (!req_valid || req_ready) begin
            send_next = (panel_items.size() != 0) &&
                        (quiet_stretch || $urandom_range(99) >= 22);
            if (send_next) req_data <= panel_items.pop_front();
            req_valid <= send_next;
         end
      end
   end

   // --------------------------------------------------------------- monitor
   task automatic check_field(input string fname, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      int      holdoff_left;
      logic    holdoff_used;
      if (reset) begin
         rsp_ready    <= 1'b0;
         holdoff_left = 0;
         holdoff_used = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_panel_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with nothing outstanding, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = pending_panel_results.pop_front();
               check_field("show_event",   16'(want.show_event),   16'(rsp_data.show_event));
               check_field("dec_event",    16'(want.dec_event),    16'(rsp_data.dec_event));
               check_field("inc_event",    16'(want.inc_event),    16'(rsp_data.inc_event));
               check_field("unlock_event", 16'(want.unlock_event),
                           16'(rsp_data.unlock_event));
               check_field("lock_level",   16'(want.lock_level),   16'(rsp_data.lock_level));
               check_field("pulse_count",  want.pulse_count,       rsp_data.pulse_count);
               check_field("input_code",   16'(want.input_code),   16'(rsp_data.input_code));
            end
         end
         // one long back-pressure window so the block fills and stalls requests
         if (!holdoff_used && results_seen >= HOLDOFF_AT) begin
            holdoff_used = 1'b1;
            holdoff_left = HOLDOFF_LEN;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_stretch || ($urandom_range(99) >= 22);
         end
      end
   end

   // ------------------------------------------------------------- sequencing
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DEBOUNCE: cfg_debounce = val[7:0];
         CSR_HOLD:     cfg_hold     = val;
         CSR_WINDOW:   cfg_window   = val;
         CSR_TIMEOUT:  cfg_timeout  = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input logic [7:0] deb, input logic [15:0] hold,
                                 input logic [15:0] win, input logic [15:0] tmo);
      write_reg(CSR_DEBOUNCE, {8'd0, deb});
      write_reg(CSR_HOLD, hold);
      write_reg(CSR_WINDOW, win);
      write_reg(CSR_TIMEOUT, tmo);
      settings_used++;
   endtask

   // every transfer answered, then an idle wait with both register stages empty
   task automatic drain();
      @(negedge clock);
      while (panel_items.size() != 0 || req_valid || pending_panel_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic queue_random(input int count, input int unsigned tick_pct);
      repeat (count) panel_items.push_back(next_panel_item(tick_pct));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one press of everything, a pulse and a code read, then ticks to clear lockouts
      panel_items.push_back(pin_item(1, 1, 1, 6'h3F, 3'h7));
      panel_items.push_back(mode_item(MODE_READ_PULSES));
      panel_items.push_back(mode_item(MODE_READ_CODE));
      repeat (101) panel_items.push_back(mode_item(MODE_TICK));
      drain();

      apply_settings(8'd0, 16'd3, 16'd1, 16'd2);
      panel_items.push_back(pin_item(1, 1, 1, 6'h00, 3'h0)); // both held, arm lines
      panel_items.push_back(mode_item(MODE_TICK));
      panel_items.push_back(mode_item(MODE_TICK));
      panel_items.push_back(pin_item(1, 1, 1, 6'h00, 3'h0)); // inside unlock window
      panel_items.push_back(pin_item(1, 0, 1, 6'h00, 3'h0)); // inc up, dec held
      panel_items.push_back(pin_item(0, 0, 1, 6'h00, 3'h0)); // suppressed release
      panel_items.push_back(pin_item(1, 0, 1, 6'h00, 3'h0));
      panel_items.push_back(pin_item(0, 0, 1, 6'h00, 3'h0)); // dec event
      panel_items.push_back(pin_item(0, 1, 1, 6'h00, 3'h0));
      panel_items.push_back(pin_item(0, 0, 1, 6'h00, 3'h0)); // inc event
      panel_items.push_back(pin_item(0, 0, 0, 6'h3F, 3'h0)); // pulse, code 4
      panel_items.push_back(mode_item(MODE_READ_CODE));
      panel_items.push_back(mode_item(MODE_READ_PULSES));
      panel_items.push_back(pin_item(0, 0, 0, 6'h00, 3'h0));
      panel_items.push_back(pin_item(0, 0, 0, 6'h3F, 3'h7)); // all lines, code 1
      panel_items.push_back(pin_item(0, 0, 0, 6'h00, 3'h0));
      panel_items.push_back(pin_item(0, 0, 0, 6'h01, 3'h0)); // code 9
      panel_items.push_back(mode_item(MODE_READ_CODE));
      panel_items.push_back(mode_item(MODE_READ_CODE));      // already cleared
      repeat (3) panel_items.push_back(mode_item(MODE_TICK));
      panel_items.push_back(pin_item(0, 0, 0, 6'h00, 3'h0)); // display expired
      panel_items.push_back(pin_item(0, 0, 1, 6'h00, 3'h0));
      queue_random(180, 35);
      drain();

      // zero hold reload, zero window and zero timeout
      apply_settings(8'd1, 16'd0, 16'd0, 16'd0);
      queue_random(220, 35);
      drain();

      apply_settings(8'd2, 16'd12, 16'd4, 16'd6);
      queue_random(220, 40);
      drain();

      apply_settings(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_random(260, 85);
      drain();

      apply_settings(8'd3, 16'd40, 16'd0, 16'hFFFF);
      queue_random(160, 45);
      drain();

      apply_settings(8'($urandom_range(4)), 16'($urandom_range(30)),
                     16'($urandom_range(8)), 16'($urandom_range(20)));
      queue_random(200, 35);
      drain();

      // burst of falling edges on the capture pin with no lockout
      apply_settings(8'd0, 16'd5, 16'd2, 16'd10);
      panel_items.push_back(mode_item(MODE_READ_PULSES));
      repeat (40) begin
         panel_items.push_back(pin_item(0, 0, 1, 6'h00, 3'h0));
         panel_items.push_back(pin_item(0, 0, 0, 6'h00, 3'h0));
      end
      panel_items.push_back(mode_item(MODE_READ_PULSES));
      drain();
      repeat (8) @(negedge clock);

      $display("%0d items over %0d register settings, %0d mismatches", items_taken,
               settings_used, mismatch_count);
      $display("events: %0d show, %0d inc, %0d dec, %0d unlock, %0d lock; %0d code reads, %0d pulse reads",
               presses_seen, inc_seen, dec_seen, unlocks_seen, locks_seen, codes_read,
               pulse_reads);
      if (mismatch_count == 0 && pending_panel_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/fpbd_pkg.sv
sv/fpbd_csr.sv
sv/fpbd_core.sv
sv/front_panel_button_debouncer_unit.sv
sv/fpbd_checker.sv
tb/front_panel_button_debouncer_unit_tb.sv
